>>> design/bacth_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the box average color threshold core
// no dependencies

package bacth_pkg;

  localparam int BLOCK_W        = 4;
  localparam int BLOCK_H        = 4;
  localparam int MAX_RAW_WIDTH  = 2048;
  localparam int MAX_RAW_HEIGHT = 4096;
  localparam int AREA           = BLOCK_W * BLOCK_H;

  localparam int NCH       = 3;
  localparam int PIX_W     = 8;
  localparam int SUM_W     = 32;   // accumulators wrap at 32 bits, as stale sums may keep growing
  localparam int SUM_DEPTH = 512;
  localparam int SUM_AW    = $clog2(SUM_DEPTH);

  localparam int COL_W   = $clog2(MAX_RAW_WIDTH);
  localparam int ROW_W   = $clog2(MAX_RAW_HEIGHT);
  localparam int WIDTH_W = 12;
  localparam int CX_W    = (BLOCK_W > 1) ? $clog2(BLOCK_W) : 1;
  localparam int CY_W    = (BLOCK_H > 1) ? $clog2(BLOCK_H) : 1;

  localparam int BCOL_W = 9;
  localparam int BROW_W = 10;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 12;

  localparam logic [PIX_W-1:0] MASK_ON  = 8'd255;
  localparam logic [PIX_W-1:0] MASK_OFF = 8'd0;

  localparam logic [WIDTH_W-1:0] RAW_WIDTH_RESET = WIDTH_W'(MAX_RAW_WIDTH);

  typedef enum logic [CFG_IW-1:0] {
    REG_CH0_LOW   = 3'd0,
    REG_CH1_LOW   = 3'd1,
    REG_CH2_LOW   = 3'd2,
    REG_CH0_HIGH  = 3'd3,
    REG_CH1_HIGH  = 3'd4,
    REG_CH2_HIGH  = 3'd5,
    REG_RAW_WIDTH = 3'd6
  } cfg_reg_t;

  typedef logic [NCH-1:0][SUM_W-1:0] sums_t;
  typedef logic [NCH-1:0][PIX_W-1:0] pix_t;

  // what the position tracker tells the datapath about one pixel
  typedef struct packed {
    logic              work;   // pixel belongs to a whole block that is kept
    logic              first;  // top-left corner of its block
    logic              last;   // bottom-right corner of its block
    logic [SUM_AW-1:0] addr;   // block column, accumulator address
    logic [BROW_W-1:0] brow;   // block row, saturated
  } pos_t;

endpackage

>>> design/bacth_pos.sv
`timescale 1ns / 1ps
// raster position tracker: pixel and block counters, frame overrun handling
// depends on bacth_pkg

module bacth_pos import bacth_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               frame_start,
  input  logic [WIDTH_W-1:0] width,
  output pos_t               pos
);

  localparam logic [ROW_W-1:0] BROW_MAX = ROW_W'((1 << BROW_W) - 1);

  logic [COL_W-1:0] col, col_next;
  logic [CX_W-1:0]  cx, cx_next;
  logic [COL_W-1:0] bx, bx_next;
  logic [ROW_W-1:0] row, row_next;
  logic [CY_W-1:0]  cy, cy_next;
  logic [ROW_W-1:0] by, by_next;
  logic             frame_over, frame_over_next;

  logic [COL_W-1:0]   cur_col, cur_bx, blk_start;
  logic [CX_W-1:0]    cur_cx;
  logic [ROW_W-1:0]   cur_row, cur_by;
  logic [CY_W-1:0]    cur_cy;
  logic               cur_over;
  logic               whole_block, row_end, frame_end;

  always_comb begin
    cur_col  = frame_start ? '0 : col;
    cur_cx   = frame_start ? '0 : cx;
    cur_bx   = frame_start ? '0 : bx;
    cur_row  = frame_start ? '0 : row;
    cur_cy   = frame_start ? '0 : cy;
    cur_by   = frame_start ? '0 : by;
    cur_over = frame_start ? 1'b0 : frame_over;

    // block fits in the row when its start plus BLOCK_W does not pass the width
    blk_start   = cur_col - COL_W'(cur_cx);
    whole_block = ((WIDTH_W+1)'(blk_start) + (WIDTH_W+1)'(BLOCK_W)) <= (WIDTH_W+1)'(width);

    pos.work  = !cur_over && whole_block && ((COL_W+1)'(cur_bx) < (COL_W+1)'(SUM_DEPTH));
    pos.first = (cur_cx == '0) && (cur_cy == '0);
    pos.last  = (cur_cx == CX_W'(BLOCK_W - 1)) && (cur_cy == CY_W'(BLOCK_H - 1));
    pos.addr  = cur_bx[SUM_AW-1:0];
    pos.brow  = (cur_by > BROW_MAX) ? BROW_MAX[BROW_W-1:0] : cur_by[BROW_W-1:0];

    row_end   = ((WIDTH_W+1)'(cur_col) + 1'b1) >= (WIDTH_W+1)'(width);
    frame_end = ((ROW_W+1)'(cur_row) + 1'b1) >= (ROW_W+1)'(MAX_RAW_HEIGHT);

    col_next        = cur_col;
    cx_next         = cur_cx;
    bx_next         = cur_bx;
    row_next        = cur_row;
    cy_next         = cur_cy;
    by_next         = cur_by;
    frame_over_next = cur_over;

    if (!cur_over) begin
      if (row_end) begin
        col_next = '0;
        cx_next  = '0;
        bx_next  = '0;
        if (frame_end) begin
          row_next        = '0;
          cy_next         = '0;
          by_next         = '0;
          frame_over_next = 1'b1;
        end else begin
          row_next = cur_row + 1'b1;
          if (cur_cy == CY_W'(BLOCK_H - 1)) begin
            cy_next = '0;
            by_next = cur_by + 1'b1;
          end else begin
            cy_next = cur_cy + 1'b1;
          end
        end
      end else begin
        col_next = cur_col + 1'b1;
        if (cur_cx == CX_W'(BLOCK_W - 1)) begin
          cx_next = '0;
          bx_next = cur_bx + 1'b1;
        end else begin
          cx_next = cur_cx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      cx         <= '0;
      bx         <= '0;
      row        <= '0;
      cy         <= '0;
      by         <= '0;
      frame_over <= 1'b0;
    end else if (accept) begin
      col        <= col_next;
      cx         <= cx_next;
      bx         <= bx_next;
      row        <= row_next;
      cy         <= cy_next;
      by         <= by_next;
      frame_over <= frame_over_next;
    end
  end

endmodule

>>> design/box_average_downscale_color_threshold_core.sv
`timescale 1ns / 1ps
// top level: config registers, block column accumulators, range threshold, result register
// depends on bacth_pkg and bacth_pos

// Takes one pixel per clock with no bubbles while out_stall is low. An accepted pixel passes
// the input register and then the result register: the pixel and the accumulator read go into
// the input register, the add and the three range compares sit in front of the result
// register. The accumulators are a 512-entry memory with one read port, read when a pixel
// is accepted, and one write port; the write of the pixel just ahead is forwarded. No
// clearing pass follows reset. in_stall rises only while a result is held by out_stall.

module box_average_downscale_color_threshold_core import bacth_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data,
  // pixel stream
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               frame_start,
  input  logic [PIX_W-1:0]   chan0,
  input  logic [PIX_W-1:0]   chan1,
  input  logic [PIX_W-1:0]   chan2,
  // block results
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   mask_pixel,
  output logic [BCOL_W-1:0]  block_col,
  output logic [BROW_W-1:0]  block_row
);

  // configuration
  logic [NCH-1:0][PIX_W-1:0] low_bound;
  logic [NCH-1:0][PIX_W-1:0] high_bound;
  logic [WIDTH_W-1:0]        raw_width;
  logic [WIDTH_W-1:0]        width_eff;

  logic in_accept, s1_adv, s1_write, s1_hit;
  pos_t pos;

  // input register stage
  logic        s1_valid;
  pos_t        s1_pos;
  pix_t        s1_px;
  sums_t       rd_sums;

  sums_t       sum_mem [SUM_DEPTH];
  sums_t       base, sum_new;
  logic [NCH-1:0] ch_ok;

  // last accumulator write, for the read that missed it
  logic              fwd_valid;
  logic [SUM_AW-1:0] fwd_addr;
  sums_t             fwd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_bound  <= '0;
      high_bound <= {NCH{MASK_ON}};
      raw_width  <= RAW_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CH0_LOW:   low_bound[0]  <= cfg_data[PIX_W-1:0];
        REG_CH1_LOW:   low_bound[1]  <= cfg_data[PIX_W-1:0];
        REG_CH2_LOW:   low_bound[2]  <= cfg_data[PIX_W-1:0];
        REG_CH0_HIGH:  high_bound[0] <= cfg_data[PIX_W-1:0];
        REG_CH1_HIGH:  high_bound[1] <= cfg_data[PIX_W-1:0];
        REG_CH2_HIGH:  high_bound[2] <= cfg_data[PIX_W-1:0];
        REG_RAW_WIDTH: raw_width     <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // zero width acts as one, oversize clamps to the maximum
  always_comb begin
    priority if (raw_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (raw_width > RAW_WIDTH_RESET) begin
      width_eff = RAW_WIDTH_RESET;
    end else begin
      width_eff = raw_width;
    end
  end

  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign s1_write  = s1_adv && s1_pos.work;

  bacth_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .frame_start (frame_start),
    .width       (width_eff),
    .pos         (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pos   <= pos;
      s1_px    <= {chan2, chan1, chan0};
      rd_sums  <= sum_mem[pos.addr];
    end
    if (s1_write) begin
      sum_mem[s1_pos.addr] <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_write) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      fwd_addr <= s1_pos.addr;
      fwd_data <= sum_new;
    end
  end

  assign s1_hit = fwd_valid && (fwd_addr == s1_pos.addr);

  // avg = sum / AREA lies in [lo, hi] exactly when lo*AREA <= sum < (hi+1)*AREA
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (s1_pos.first) begin
        base[c] = '0;
      end else if (s1_hit) begin
        base[c] = fwd_data[c];
      end else begin
        base[c] = rd_sums[c];
      end
      sum_new[c] = base[c] + SUM_W'(s1_px[c]);
      ch_ok[c]   = (sum_new[c] >= SUM_W'(low_bound[c]) * SUM_W'(AREA)) &&
                   (sum_new[c] < (SUM_W'(high_bound[c]) + 1'b1) * SUM_W'(AREA));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_pos.work && s1_pos.last;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_pos.work && s1_pos.last) begin
      mask_pixel <= (&ch_ok) ? MASK_ON : MASK_OFF;
      block_col  <= BCOL_W'(s1_pos.addr);
      block_row  <= s1_pos.brow;
    end
  end

  // input side is held back only by a full stage
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall with empty input stage");

  // a new result only comes from a block corner that left the input stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid && out_stall)) |->
      $past(s1_adv && s1_pos.work && s1_pos.last))
    else $error("result without completed block");

  // the forward register tracks the accumulator write just made
  a_forward_tracks: assert property (@(posedge clk) disable iff (rst)
    s1_write |=> (fwd_valid && fwd_addr == $past(s1_pos.addr)))
    else $error("forward register missed a write");

  a_mask_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mask_pixel == MASK_ON || mask_pixel == MASK_OFF))
    else $error("mask value neither on nor off");

endmodule
